### sv/hcc_pkg.sv
// Shared types and constants for the Hamiltonian cycle checker.
package hcc_pkg;

  // Input command codes carried on tuser.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_PATH = 1'b1;

  // Field and counter widths fixed by the item format.
  localparam int ID_W    = 8;
  localparam int LEN_W   = 9;
  localparam int COUNT_W = 9;
  localparam int EPOCH_W = 8;

  localparam logic [LEN_W-1:0]   LEN_MAX    = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_INIT = EPOCH_W'(1);

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR_ALL,
    S_CLEAR_VIS,
    S_IDLE,
    S_DONE
  } hcc_state_t;

  // Operation request toward the adjacency memory.
  typedef struct packed {
    logic rd;
    logic set;
    logic clr;
  } hcc_mem_op_t;

endpackage

### sv/hcc_adj_mem.sv
// Adjacency matrix memory: one row per vertex, single port, bit writes and row clears.
module hcc_adj_mem #(
  parameter int MAX_VERTICES = 256,
  parameter int VW           = 8
) (
  input  logic                    clk,
  input  hcc_pkg::hcc_mem_op_t    op,
  input  logic [VW-1:0]           addr,
  input  logic [VW-1:0]           col,
  output logic [MAX_VERTICES-1:0] rd_row
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];

  // One access per cycle: clear a row, set one bit of a row, or read a row.
  always_ff @(posedge clk) begin
    if (op.clr) begin
      mem[addr] <= '0;
    end else if (op.set) begin
      mem[addr][col] <= 1'b1;
    end
    if (op.rd) begin
      rd_row <= mem[addr];
    end
  end

endmodule

### sv/hcc_vis_mem.sv
// Visited memory: one epoch tag per vertex, one write and one read port.
module hcc_vis_mem #(
  parameter int MAX_VERTICES = 256,
  parameter int VW           = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [VW-1:0]               waddr,
  input  logic [hcc_pkg::EPOCH_W-1:0] wdata,
  input  logic                        re,
  input  logic [VW-1:0]               raddr,
  output logic [hcc_pkg::EPOCH_W-1:0] rdata
);

  logic [hcc_pkg::EPOCH_W-1:0] mem [MAX_VERTICES];

  // A vertex counts as visited when its tag equals the current query epoch.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/hamiltonian_cycle_checker.sv
// Top level of the Hamiltonian cycle checker: control, query state and memories.
//
//   channel   direction  payload (low bit first)
//   s_axis    in         tdata: vertex_a, vertex_b; tuser: command; tlast: last
//   m_axis    out        tdata: is_cycle, zero fill to 8 bits
//   cfg       in         cfg_wdata: vertex_count, written when cfg_wen is high
//
// Every item is accepted in S_IDLE, which issues one access to the single-port
// adjacency memory; S_DONE then uses the registered read data and writes back.
// An edge item sets one direction in S_IDLE and the other in S_DONE.
// After reset a clearing pass over all MAX_VERTICES entries empties both memories.
// Visited marks are epoch tags; every 255th verdict adds a pass that clears them.
// A path item marked last waits in S_DONE while the previous verdict
// has not been taken.
module hamiltonian_cycle_checker #(
  parameter int MAX_VERTICES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // vertex_a [7:0], vertex_b [15:8]
  input  logic        s_axis_tuser,  // command
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // is_cycle [0], zeros above
  input  logic        cfg_wen,
  input  logic [8:0]  cfg_wdata
);

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int IDS = 1 << hcc_pkg::ID_W;

  hcc_pkg::hcc_state_t  state, state_next;
  hcc_pkg::hcc_mem_op_t adj_op;

  logic [VW-1:0] id_map [IDS];
  logic [VW-1:0] a_in, b_in;
  logic          in_fire, proceed, verdict_due;

  logic [VW-1:0]                 clr_cnt;
  logic                          clr_end;
  logic [hcc_pkg::EPOCH_W-1:0]   epoch;
  logic [hcc_pkg::COUNT_W-1:0]   vertex_count;

  logic                          cmd_q, last_q;
  logic [VW-1:0]                 a_q, b_q;

  logic [VW-1:0]                 first_vertex, prev_vertex;
  logic [hcc_pkg::LEN_W-1:0]     path_length;
  logic [hcc_pkg::COUNT_W-1:0]   distinct_count;
  logic                          steps_ok;
  logic                          out_valid, out_bit, verdict_fire;

  logic [VW-1:0]                 adj_addr, adj_col;
  logic [MAX_VERTICES-1:0]       adj_row;
  logic                          adj_bit;
  logic                          vis_we, vis_re;
  logic [VW-1:0]                 vis_waddr;
  logic [hcc_pkg::EPOCH_W-1:0]   vis_wdata, vis_rdata;

  logic [VW-1:0]                 first_sel;
  logic                          steps_ok_next, hit, ok;
  logic [hcc_pkg::LEN_W-1:0]     len_next;
  logic [hcc_pkg::COUNT_W-1:0]   dist_next;

  // Vertex ids fold onto the memory depth through a constant table.
  for (genvar g = 0; g < IDS; g++) begin : g_id_map
    assign id_map[g] = VW'(g % MAX_VERTICES);
  end

  assign a_in    = id_map[s_axis_tdata[7:0]];
  assign b_in    = id_map[s_axis_tdata[15:8]];
  assign in_fire = s_axis_tvalid & s_axis_tready;
  assign clr_end = (clr_cnt == VW'(MAX_VERTICES - 1));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_bit};

  // Memories.
  hcc_adj_mem #(.MAX_VERTICES(MAX_VERTICES), .VW(VW)) u_adj (
    .clk    (clk),
    .op     (adj_op),
    .addr   (adj_addr),
    .col    (adj_col),
    .rd_row (adj_row)
  );

  hcc_vis_mem #(.MAX_VERTICES(MAX_VERTICES), .VW(VW)) u_vis (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (vis_re),
    .raddr (a_in),
    .rdata (vis_rdata)
  );

  // Step evaluation from the registered memory data.
  assign adj_bit       = adj_row[a_q];
  assign first_sel     = (path_length == '0) ? a_q : first_vertex;
  assign steps_ok_next = steps_ok & ((path_length == '0) | adj_bit);
  assign hit           = (vis_rdata == epoch);
  assign dist_next     = distinct_count + hcc_pkg::COUNT_W'(!hit);
  assign len_next      = (path_length == hcc_pkg::LEN_MAX) ? path_length
                                                           : path_length + 1'b1;
  assign ok = ({1'b0, len_next} == ({1'b0, vertex_count} + 10'd1)) &&
              (first_sel == a_q) && (dist_next == vertex_count) && steps_ok_next;
  assign verdict_due  = (cmd_q == hcc_pkg::CMD_PATH) && last_q;
  assign verdict_fire = (state == hcc_pkg::S_DONE) && proceed && verdict_due;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      hcc_pkg::S_CLEAR_ALL, hcc_pkg::S_CLEAR_VIS: begin
        if (clr_end) state_next = hcc_pkg::S_IDLE;
      end
      hcc_pkg::S_IDLE: begin
        if (in_fire) state_next = hcc_pkg::S_DONE;
      end
      hcc_pkg::S_DONE: begin
        if (proceed) begin
          if (verdict_due && epoch == hcc_pkg::EPOCH_LAST) begin
            state_next = hcc_pkg::S_CLEAR_VIS;
          end else begin
            state_next = hcc_pkg::S_IDLE;
          end
        end
      end
      default: state_next = hcc_pkg::S_CLEAR_ALL;
    endcase
  end

  // Memory requests and handshake.
  always_comb begin
    adj_op        = '0;
    adj_addr      = '0;
    adj_col       = '0;
    vis_we        = 1'b0;
    vis_re        = 1'b0;
    vis_waddr     = '0;
    vis_wdata     = '0;
    s_axis_tready = 1'b0;
    proceed       = 1'b0;
    case (state)
      hcc_pkg::S_CLEAR_ALL: begin
        adj_op.clr = 1'b1;
        adj_addr   = clr_cnt;
        vis_we     = 1'b1;
        vis_waddr  = clr_cnt;
      end
      hcc_pkg::S_CLEAR_VIS: begin
        vis_we    = 1'b1;
        vis_waddr = clr_cnt;
      end
      hcc_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          if (s_axis_tuser == hcc_pkg::CMD_PATH) begin
            adj_op.rd = 1'b1;
            adj_addr  = prev_vertex;
            vis_re    = 1'b1;
          end else begin
            adj_op.set = 1'b1;
            adj_addr   = a_in;
            adj_col    = b_in;
          end
        end
      end
      hcc_pkg::S_DONE: begin
        proceed = !verdict_due || !out_valid || m_axis_tready;
        if (proceed) begin
          if (cmd_q == hcc_pkg::CMD_EDGE) begin
            adj_op.set = 1'b1;
            adj_addr   = b_q;
            adj_col    = a_q;
          end else begin
            vis_we    = 1'b1;
            vis_waddr = a_q;
            vis_wdata = epoch;
          end
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tuser;
      last_q <= s_axis_tlast;
      a_q    <= a_in;
      b_q    <= b_in;
    end
  end

  // Control, configuration and per-query state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= hcc_pkg::S_CLEAR_ALL;
      clr_cnt        <= '0;
      epoch          <= hcc_pkg::EPOCH_INIT;
      vertex_count   <= hcc_pkg::COUNT_W'(1);
      first_vertex   <= '0;
      prev_vertex    <= '0;
      path_length    <= '0;
      distinct_count <= '0;
      steps_ok       <= 1'b1;
      out_valid      <= 1'b0;
      out_bit        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) vertex_count <= cfg_wdata;

      if (state == hcc_pkg::S_CLEAR_ALL || state == hcc_pkg::S_CLEAR_VIS) begin
        clr_cnt <= clr_end ? '0 : clr_cnt + 1'b1;
      end

      // The verdict register fills on a commit and empties when its beat is taken.
      if (verdict_fire) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      // Path step commit; a verdict also opens a fresh query.
      if (state == hcc_pkg::S_DONE && proceed && cmd_q == hcc_pkg::CMD_PATH) begin
        if (last_q) begin
          out_bit        <= ok;
          first_vertex   <= '0;
          prev_vertex    <= '0;
          path_length    <= '0;
          distinct_count <= '0;
          steps_ok       <= 1'b1;
          epoch          <= (epoch == hcc_pkg::EPOCH_LAST) ? hcc_pkg::EPOCH_INIT
                                                           : epoch + 1'b1;
        end else begin
          first_vertex   <= first_sel;
          prev_vertex    <= a_q;
          path_length    <= len_next;
          distinct_count <= dist_next;
          steps_ok       <= steps_ok_next;
        end
      end
    end
  end

  // A verdict beat appears only right after a path item marked last commits.
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == hcc_pkg::S_DONE && cmd_q == hcc_pkg::CMD_PATH
                               && last_q))
    else $error("verdict raised without a last path item");

  // A waiting verdict is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> out_valid && $stable(out_bit))
    else $error("pending verdict lost");

  // Distinct vertices can never outnumber the steps of the path.
  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    distinct_count <= path_length)
    else $error("distinct count exceeds path length");

  // The epoch tag zero is reserved for cleared entries.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == hcc_pkg::S_IDLE |-> epoch != '0)
    else $error("epoch collides with cleared tag");

  // Nothing is accepted while a clearing pass runs.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == hcc_pkg::S_CLEAR_ALL || state == hcc_pkg::S_CLEAR_VIS) |-> !in_fire)
    else $error("item accepted during clearing pass");

endmodule
